### sv/fpv_pkg.sv
package fpv_pkg;

    // Element store
    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = 11;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = QP_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCULATION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 2'd2;

    // Request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // round(2^32 / (4*pi)), Q0.32
    localparam int K_W = 29;
    localparam logic [K_W-1:0] INV_FOUR_PI = 29'd341782638;

    // Datapath widths
    localparam int GK_W      = 60;   // |Gamma| * K
    localparam int S_W       = 66;   // sum of squares, Q34.32
    localparam int ROOT_W    = S_W / 2;
    localparam int N_W       = 34;   // distance, Q18.16
    localparam int DEN_W     = 107;  // n^3 * 2^8
    localparam int NUM_W     = 124;  // gk * |C|
    localparam int Q_W       = 49;   // term quotient
    localparam int VEL_W     = 60;   // velocity accumulators
    localparam int OUT_W     = 48;
    localparam int MAC_W     = 126;
    localparam int MAC_A_W   = 66;
    localparam int MAC_B_W   = 64;
    localparam int MAC_DIG_W = 16;

    localparam logic [Q_W-1:0] TERM_CAP = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic               kind;
        logic [9:0]         element_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
    } fpv_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] vel_x;
        logic signed [OUT_W-1:0] vel_y;
        logic signed [OUT_W-1:0] vel_z;
        logic                    saturated;
    } fpv_out_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
    } fpv_elem_t;

    typedef struct packed {
        logic [CNT_W-1:0]   element_count;
        logic signed [31:0] circulation;
        logic [30:0]        min_distance;
    } fpv_cfg_t;

endpackage

### sv/fpv_front.sv
module fpv_front
    import fpv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  fpv_in_t req_data,
    output logic    q_valid,
    output fpv_in_t q_item,
    input  logic    q_pop
);

    localparam logic [QC_W-1:0] QUEUE_FULL = QC_W'(QUEUE_DEPTH);

    fpv_in_t         fifo_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            push, pop;

    assign req_ready = (count_reg != QUEUE_FULL);
    assign q_valid   = (count_reg != '0);
    assign q_item    = fifo_mem[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= req_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QUEUE_FULL)
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

### sv/fpv_sqrt.sv
module fpv_sqrt
    import fpv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [S_W-1:0] radicand,
    output logic           done,
    output logic [N_W-1:0] root
);

    localparam logic [5:0] LAST_STEP = 6'(ROOT_W - 1);

    logic [S_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [5:0]        step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [ROOT_W+2:0] rem_t, trial;
    logic              ge;

    // One root bit per cycle, restoring
    always_comb
    begin
        rem_t     = {rem_reg, rad_reg[S_W-1:S_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_t >= trial);
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next  = {rad_reg[S_W-3:0], 2'b00};
            rem_next  = ge ? (ROOT_W+1)'(rem_t - trial) : rem_t[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign root = N_W'(root_reg);

endmodule

### sv/fpv_div.sv
module fpv_div
    import fpv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot,
    output logic             ovf
);

    localparam logic [5:0] LAST_STEP = 6'(Q_W - 1);

    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   lo_reg, lo_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [5:0]       step_reg, step_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [DEN_W-1:0] num_hi;
    logic [DEN_W:0]   r_t;
    logic             ge;

    // Quotient of 2^Q_W or more is flagged before the bit loop
    always_comb
    begin
        num_hi    = DEN_W'(num[NUM_W-1:Q_W]);
        r_t       = {r_reg, lo_reg[Q_W-1]};
        ge        = (r_t >= {1'b0, den_reg});
        r_next    = r_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        step_next = step_reg;
        run_next  = run_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next  = den;
            r_next    = num_hi;
            lo_next   = num[Q_W-1:0];
            q_next    = '0;
            step_next = '0;
            if (num_hi >= den)
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                ovf_next = 1'b0;
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            r_next    = ge ? DEN_W'(r_t - {1'b0, den_reg}) : r_t[DEN_W-1:0];
            lo_next   = {lo_reg[Q_W-2:0], 1'b0};
            q_next    = {q_reg[Q_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        den_reg  <= den_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

### sv/fpv_back.sv
module fpv_back
    import fpv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fpv_cfg_t cfg,
    input  logic     q_valid,
    input  fpv_in_t  q_item,
    output logic     q_pop,
    output logic     resp_valid,
    input  logic     resp_ready,
    output fpv_out_t resp_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_DIFF  = 9'b000000100,
        S_SQ    = 9'b000001000,
        S_SQRT  = 9'b000010000,
        S_CUBE  = 9'b000100000,
        S_CROSS = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] OP_END = 2'd3;
    localparam logic [1:0] MAC_LAST = 2'(MAC_B_W / MAC_DIG_W - 1);

    function automatic logic [31:0] mag_t(input logic signed [31:0] v);
        logic [31:0] u;
        u = v[31] ? 32'(-v) : 32'(v);
        return u;
    endfunction

    function automatic logic [31:0] mag_d(input logic signed [32:0] v);
        logic [32:0] u;
        u = v[32] ? 33'(-v) : 33'(v);
        return u[31:0];
    endfunction

    // Sequencer state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       axis_reg, axis_next;

    // Payload
    logic signed [31:0]    px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [31:0]    tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    logic signed [32:0]    dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [GK_W-1:0]       gk_reg, gk_next;
    logic                  gneg_reg, gneg_next;
    logic                  cneg_reg, cneg_next;
    logic [N_W-1:0]        n_reg, n_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic signed [VEL_W-1:0] vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;
    logic                  sat_reg, sat_next;
    logic                  resp_valid_reg, resp_valid_next;
    fpv_out_t              resp_reg, resp_next;

    // Multiply-accumulate unit, one 16-bit digit of B per cycle
    logic [MAC_W-1:0]   mac_acc_reg, mac_acc_next;
    logic [MAC_A_W-1:0] mac_a_reg, mac_a_next;
    logic [MAC_B_W-1:0] mac_b_reg, mac_b_next;
    logic               mac_neg_reg, mac_neg_next;
    logic [1:0]         mac_dig_reg, mac_dig_next;
    logic               mac_run_reg, mac_run_next;
    logic               mac_start, mac_clr, mac_neg_in;
    logic [MAC_A_W-1:0] mac_a_in;
    logic [MAC_B_W-1:0] mac_b_in;
    logic [MAC_A_W+MAC_DIG_W-1:0] mac_prod;
    logic [MAC_W-1:0]   mac_term, acc_abs;

    // Element store
    fpv_elem_t          elem_mem [MAX_ELEMENTS];
    fpv_elem_t          mem_q;
    logic               mem_we, mem_re;

    // Shared units
    logic               sqrt_start, sqrt_done;
    logic [N_W-1:0]     sqrt_root;
    logic               div_start, div_done, div_ovf;
    logic [Q_W-1:0]     div_quot;

    // Selection helpers
    logic signed [32:0] d_sq, da, db;
    logic signed [31:0] ta, tb;
    logic [CNT_W-1:0]   count_q;
    logic [31:0]        circ_mag;
    logic [Q_W-1:0]     term;
    logic               term_sat, term_neg;
    logic signed [VEL_W-1:0] v_cur, v_sum, term_s;
    logic [CNT_W-1:0]   idx_inc;
    logic               last_elem;
    logic               ovx_p, ovx_n, ovy_p, ovy_n, ovz_p, ovz_n;

    fpv_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mac_acc_reg[S_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    fpv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mac_acc_reg[NUM_W-1:0]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot),
        .ovf   (div_ovf)
    );

    always_comb
    begin
        mac_prod = mac_a_reg * mac_b_reg[MAC_DIG_W-1:0];
        mac_term = MAC_W'(mac_prod) << (MAC_DIG_W * mac_dig_reg);
        acc_abs  = mac_acc_reg[MAC_W-1] ? -mac_acc_reg : mac_acc_reg;
    end

    always_comb
    begin
        case (op_reg)
            2'd0:    d_sq = dx_reg;
            2'd1:    d_sq = dy_reg;
            default: d_sq = dz_reg;
        endcase
        // C = Ta*db - Tb*da, axes a and b following the current one
        case (axis_reg)
            AX_X:
            begin
                ta = ty_reg; tb = tz_reg; da = dy_reg; db = dz_reg; v_cur = vx_reg;
            end
            AX_Y:
            begin
                ta = tz_reg; tb = tx_reg; da = dz_reg; db = dx_reg; v_cur = vy_reg;
            end
            default:
            begin
                ta = tx_reg; tb = ty_reg; da = dx_reg; db = dy_reg; v_cur = vz_reg;
            end
        endcase
        count_q  = (cfg.element_count > CNT_W'(MAX_ELEMENTS)) ?
                   CNT_W'(MAX_ELEMENTS) : cfg.element_count;
        circ_mag = mag_t(cfg.circulation);
        term_sat = div_ovf || (div_quot > TERM_CAP);
        term     = term_sat ? TERM_CAP : div_quot;
        term_neg = gneg_reg ^ cneg_reg;
        term_s   = VEL_W'(term);
        v_sum    = term_neg ? v_cur - term_s : v_cur + term_s;
        idx_inc  = idx_reg + 1'b1;
        last_elem = (idx_inc == count_reg);
        ovx_p = !vx_reg[VEL_W-1] && (|vx_reg[VEL_W-2:OUT_W-1]);
        ovx_n = vx_reg[VEL_W-1] && !(&vx_reg[VEL_W-2:OUT_W-1]);
        ovy_p = !vy_reg[VEL_W-1] && (|vy_reg[VEL_W-2:OUT_W-1]);
        ovy_n = vy_reg[VEL_W-1] && !(&vy_reg[VEL_W-2:OUT_W-1]);
        ovz_p = !vz_reg[VEL_W-1] && (|vz_reg[VEL_W-2:OUT_W-1]);
        ovz_n = vz_reg[VEL_W-1] && !(&vz_reg[VEL_W-2:OUT_W-1]);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg;
        tx_next = tx_reg; ty_next = ty_reg; tz_next = tz_reg;
        dx_next = dx_reg; dy_next = dy_reg; dz_next = dz_reg;
        gk_next    = gk_reg;
        gneg_next  = gneg_reg;
        cneg_next  = cneg_reg;
        n_next     = n_reg;
        den_next   = den_reg;
        vx_next = vx_reg; vy_next = vy_reg; vz_next = vz_reg;
        sat_next   = sat_reg;
        resp_next  = resp_reg;
        resp_valid_next = resp_valid_reg && !resp_ready;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        mac_start  = 1'b0;
        mac_clr    = 1'b0;
        mac_neg_in = 1'b0;
        mac_a_in   = '0;
        mac_b_in   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind == KIND_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        px_next = q_item.pos_x;
                        py_next = q_item.pos_y;
                        pz_next = q_item.pos_z;
                        count_next = count_q;
                        gk_next    = GK_W'(circ_mag) * GK_W'(INV_FOUR_PI);
                        gneg_next  = cfg.circulation[31];
                        vx_next = '0; vy_next = '0; vz_next = '0;
                        sat_next   = 1'b0;
                        idx_next   = '0;
                        state_next = (count_q == '0) ? S_DONE : S_READ;
                    end
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                dx_next = {px_reg[31], px_reg} - {mem_q.pos_x[31], mem_q.pos_x};
                dy_next = {py_reg[31], py_reg} - {mem_q.pos_y[31], mem_q.pos_y};
                dz_next = {pz_reg[31], pz_reg} - {mem_q.pos_z[31], mem_q.pos_z};
                tx_next = mem_q.tan_x;
                ty_next = mem_q.tan_y;
                tz_next = mem_q.tan_z;
                op_next    = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                // Sum the three squares into one accumulator
                if (!mac_run_reg)
                begin
                    if (op_reg != OP_END)
                    begin
                        mac_start = 1'b1;
                        mac_clr   = (op_reg == 2'd0);
                        mac_a_in  = MAC_A_W'(mag_d(d_sq));
                        mac_b_in  = MAC_B_W'(mag_d(d_sq));
                        op_next   = op_reg + 1'b1;
                    end
                    else
                    begin
                        sqrt_start = 1'b1;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    n_next = sqrt_root;
                    if (sqrt_root > N_W'(cfg.min_distance))
                    begin
                        op_next    = '0;
                        state_next = S_CUBE;
                    end
                    else if (last_elem)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_READ;
                    end
                end
            end
            S_CUBE:
            begin
                if (!mac_run_reg)
                begin
                    case (op_reg)
                        2'd0:
                        begin
                            mac_start = 1'b1;
                            mac_clr   = 1'b1;
                            mac_a_in  = MAC_A_W'(n_reg);
                            mac_b_in  = MAC_B_W'(n_reg);
                            op_next   = 2'd1;
                        end
                        2'd1:
                        begin
                            mac_start = 1'b1;
                            mac_clr   = 1'b1;
                            mac_a_in  = mac_acc_reg[MAC_A_W-1:0];
                            mac_b_in  = MAC_B_W'(n_reg);
                            op_next   = 2'd2;
                        end
                        default:
                        begin
                            den_next   = {mac_acc_reg[DEN_W-9:0], 8'b0};
                            op_next    = '0;
                            axis_next  = AX_X;
                            state_next = S_CROSS;
                        end
                    endcase
                end
            end
            S_CROSS:
            begin
                if (!mac_run_reg)
                begin
                    case (op_reg)
                        2'd0:
                        begin
                            mac_start  = 1'b1;
                            mac_clr    = 1'b1;
                            mac_a_in   = MAC_A_W'(mag_t(ta));
                            mac_b_in   = MAC_B_W'(mag_d(db));
                            mac_neg_in = ta[31] ^ db[32];
                            op_next    = 2'd1;
                        end
                        2'd1:
                        begin
                            mac_start  = 1'b1;
                            mac_a_in   = MAC_A_W'(mag_t(tb));
                            mac_b_in   = MAC_B_W'(mag_d(da));
                            mac_neg_in = !(tb[31] ^ da[32]);
                            op_next    = 2'd2;
                        end
                        2'd2:
                        begin
                            // Numerator gk * |C|, sign kept aside
                            cneg_next = mac_acc_reg[MAC_W-1];
                            mac_start = 1'b1;
                            mac_clr   = 1'b1;
                            mac_a_in  = MAC_A_W'(acc_abs[MAC_B_W-1:0]);
                            mac_b_in  = MAC_B_W'(gk_reg);
                            op_next   = OP_END;
                        end
                        default:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (term_sat)
                    begin
                        sat_next = 1'b1;
                    end
                    case (axis_reg)
                        AX_X:    vx_next = v_sum;
                        AX_Y:    vy_next = v_sum;
                        default: vz_next = v_sum;
                    endcase
                    if (axis_reg != AX_Z)
                    begin
                        axis_next  = axis_reg + 1'b1;
                        op_next    = '0;
                        state_next = S_CROSS;
                    end
                    else if (last_elem)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                if (!resp_valid_reg || resp_ready)
                begin
                    resp_valid_next = 1'b1;
                    resp_next.vel_x = ovx_p ? {1'b0, {(OUT_W-1){1'b1}}} :
                                      ovx_n ? {1'b1, {(OUT_W-1){1'b0}}} : vx_reg[OUT_W-1:0];
                    resp_next.vel_y = ovy_p ? {1'b0, {(OUT_W-1){1'b1}}} :
                                      ovy_n ? {1'b1, {(OUT_W-1){1'b0}}} : vy_reg[OUT_W-1:0];
                    resp_next.vel_z = ovz_p ? {1'b0, {(OUT_W-1){1'b1}}} :
                                      ovz_n ? {1'b1, {(OUT_W-1){1'b0}}} : vz_reg[OUT_W-1:0];
                    resp_next.saturated = sat_reg || ovx_p || ovx_n || ovy_p || ovy_n
                                          || ovz_p || ovz_n;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mac_acc_next = mac_acc_reg;
        mac_a_next   = mac_a_reg;
        mac_b_next   = mac_b_reg;
        mac_neg_next = mac_neg_reg;
        mac_dig_next = mac_dig_reg;
        mac_run_next = mac_run_reg;
        if (mac_start)
        begin
            mac_acc_next = mac_clr ? '0 : mac_acc_reg;
            mac_a_next   = mac_a_in;
            mac_b_next   = mac_b_in;
            mac_neg_next = mac_neg_in;
            mac_dig_next = '0;
            mac_run_next = 1'b1;
        end
        else if (mac_run_reg)
        begin
            mac_acc_next = mac_neg_reg ? mac_acc_reg - mac_term : mac_acc_reg + mac_term;
            mac_b_next   = mac_b_reg >> MAC_DIG_W;
            mac_dig_next = mac_dig_reg + 1'b1;
            mac_run_next = (mac_dig_reg != MAC_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mac_run_reg    <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mac_run_reg    <= mac_run_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        idx_reg   <= idx_next;
        op_reg    <= op_next;
        axis_reg  <= axis_next;
        px_reg <= px_next; py_reg <= py_next; pz_reg <= pz_next;
        tx_reg <= tx_next; ty_reg <= ty_next; tz_reg <= tz_next;
        dx_reg <= dx_next; dy_reg <= dy_next; dz_reg <= dz_next;
        gk_reg   <= gk_next;
        gneg_reg <= gneg_next;
        cneg_reg <= cneg_next;
        n_reg    <= n_next;
        den_reg  <= den_next;
        vx_reg <= vx_next; vy_reg <= vy_next; vz_reg <= vz_next;
        sat_reg  <= sat_next;
        resp_reg <= resp_next;
        mac_acc_reg <= mac_acc_next;
        mac_a_reg   <= mac_a_next;
        mac_b_reg   <= mac_b_next;
        mac_neg_reg <= mac_neg_next;
        mac_dig_reg <= mac_dig_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            elem_mem[q_item.element_index[ADDR_W-1:0]] <= '{
                pos_x: q_item.pos_x, pos_y: q_item.pos_y, pos_z: q_item.pos_z,
                tan_x: q_item.tan_x, tan_y: q_item.tan_y, tan_z: q_item.tan_z};
        end
        if (mem_re)
        begin
            mem_q <= elem_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp_data  = resp_reg;

    assert property (@(posedge clk) disable iff (!rst_n) mac_start |-> !mac_run_reg)
        else $error("multiply started while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (idx_reg < count_reg))
        else $error("element read beyond count");
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!resp_valid_reg || resp_ready)) |=> resp_valid_reg)
        else $error("finished query left no result");

endmodule

### sv/filament_point_velocity.sv
// Channel   | Signals                          | Moves
// ----------+----------------------------------+-----------------------------------
// request   | req_valid, req_ready, req_data   | element load or velocity query
// response  | resp_valid, resp_ready, resp_data| induced velocity and saturation
// config    | cfg_we, cfg_index, cfg_data      | element_count, circulation, cutoff
//
// A load request is written to the element store as the sequencer takes it
// from the queue. For each element a query runs the 33-step square root; an
// element that contributes also runs the 49-step divider once per axis. A
// term whose quotient overflows skips the divider's bit loop.
// Reset clears the queue, the sequencer and the result valid flag; the element
// store holds whatever was last loaded and is not cleared.
// The queue takes requests while the sequencer works; a held result stalls
// only the next query's final step.
module filament_point_velocity
    import fpv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  fpv_in_t               req_data,
    output logic                  resp_valid,
    input  logic                  resp_ready,
    output fpv_out_t              resp_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fpv_cfg_t cfg_reg, cfg_next;
    logic     q_valid;
    fpv_in_t  q_item;
    logic     q_pop;

    // Register writes; an unknown index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ELEMENT_COUNT: cfg_next.element_count = cfg_data[CNT_W-1:0];
                REG_CIRCULATION:   cfg_next.circulation   = cfg_data;
                REG_MIN_DISTANCE:  cfg_next.min_distance  = cfg_data[30:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.element_count <= '0;
            cfg_reg.circulation   <= 32'sd65536;
            cfg_reg.min_distance  <= 31'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: hold incoming requests in order, loads and queries alike
    fpv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Back: write loads into the store, walk the store for queries
    fpv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp_data  (resp_data)
    );

endmodule

### verif/filament_point_velocity_checker.sv
module filament_point_velocity_checker
    import fpv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  fpv_in_t               req_data,
    input  logic                  resp_valid,
    input  logic                  resp_ready,
    input  fpv_out_t              resp_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    outstanding,
    output int                    errors,
    output int                    checked
);

    localparam logic signed [63:0] VEL_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] VEL_MIN = -64'sd140737488355328;
    localparam logic [127:0]       TERM_LIMIT = 128'd1 << 48;

    fpv_elem_t          elem_store [MAX_ELEMENTS];
    logic [CNT_W-1:0]   count_reg;
    logic signed [31:0] gamma_reg;
    logic [30:0]        cutoff_reg;
    fpv_out_t           velocity_queue [$];

    initial
    begin
        outstanding = 0;
        errors      = 0;
        checked     = 0;
        count_reg   = '0;
        gamma_reg   = 32'sd65536;
        cutoff_reg  = 31'd1;
    end

    function automatic fpv_out_t induced_velocity(fpv_in_t rq);
        fpv_out_t           res;
        logic signed [63:0] acc [3];
        logic signed [63:0] g64;
        logic signed [32:0] pt [3];
        logic signed [32:0] el [3];
        logic signed [32:0] tg [3];
        logic signed [32:0] d [3];
        logic signed [65:0] p1, p2, cr;
        logic [32:0]        dm;
        logic [65:0]        cm;
        logic [127:0]       gk, s, n, cand, den, num, quo, term;
        logic               sat;
        int                 cnt, i, k, b, ia, ib;
        acc = '{64'sd0, 64'sd0, 64'sd0};
        sat = 1'b0;
        cnt = (count_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(count_reg);
        g64 = gamma_reg;
        gk  = 128'(g64 < 0 ? -g64 : g64) * 128'(INV_FOUR_PI);
        pt[0] = rq.pos_x; pt[1] = rq.pos_y; pt[2] = rq.pos_z;
        for (i = 0; i < cnt; i++)
        begin
            el[0] = elem_store[i].pos_x; el[1] = elem_store[i].pos_y;
            el[2] = elem_store[i].pos_z;
            tg[0] = elem_store[i].tan_x; tg[1] = elem_store[i].tan_y;
            tg[2] = elem_store[i].tan_z;
            s = '0;
            for (k = 0; k < 3; k++)
            begin
                d[k] = pt[k] - el[k];
                dm   = d[k] < 0 ? -d[k] : d[k];
                s    = s + 128'(dm) * 128'(dm);
            end
            // floor square root, one bit at a time from the top
            n = '0;
            for (b = 33; b >= 0; b--)
            begin
                cand = n | (128'd1 << b);
                if (cand * cand <= s)
                    n = cand;
            end
            if (n <= 128'(cutoff_reg))
                continue;
            den = (n * n * n) << 8;
            for (k = 0; k < 3; k++)
            begin
                ia  = (k + 1) % 3;
                ib  = (k + 2) % 3;
                p1  = tg[ia] * d[ib];
                p2  = tg[ib] * d[ia];
                cr  = p1 - p2;
                cm  = cr < 0 ? -cr : cr;
                num = gk * 128'(cm);
                quo = num / den;
                if (quo > TERM_LIMIT)
                begin
                    term = TERM_LIMIT;
                    sat  = 1'b1;
                end
                else
                    term = quo;
                if ((g64 < 0) != (cr < 0))
                    acc[k] = acc[k] - $signed(term[63:0]);
                else
                    acc[k] = acc[k] + $signed(term[63:0]);
            end
        end
        for (k = 0; k < 3; k++)
        begin
            if (acc[k] > VEL_MAX)
            begin
                acc[k] = VEL_MAX;
                sat    = 1'b1;
            end
            if (acc[k] < VEL_MIN)
            begin
                acc[k] = VEL_MIN;
                sat    = 1'b1;
            end
        end
        res.vel_x     = acc[0][OUT_W-1:0];
        res.vel_y     = acc[1][OUT_W-1:0];
        res.vel_z     = acc[2][OUT_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    always @(posedge clk)
    begin
        fpv_out_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ELEMENT_COUNT: count_reg  = cfg_data[CNT_W-1:0];
                    REG_CIRCULATION:   gamma_reg  = cfg_data;
                    REG_MIN_DISTANCE:  cutoff_reg = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                if (req_data.kind == KIND_LOAD)
                    elem_store[req_data.element_index] = '{req_data.pos_x, req_data.pos_y,
                        req_data.pos_z, req_data.tan_x, req_data.tan_y, req_data.tan_z};
                else
                    velocity_queue = {velocity_queue, induced_velocity(req_data)};
            end
            if (resp_valid && resp_ready)
            begin
                if (velocity_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: velocity result with no query pending: %h",
                                 resp_data);
                end
                else
                begin
                    want = velocity_queue.pop_front();
                    checked++;
                    if (resp_data.vel_x !== want.vel_x || resp_data.vel_y !== want.vel_y ||
                        resp_data.vel_z !== want.vel_z ||
                        resp_data.saturated !== want.saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("ERROR: velocity mismatch exp %h %h %h sat %b",
                                     want.vel_x, want.vel_y, want.vel_z, want.saturated);
                            $display("       got %h %h %h sat %b",
                                     resp_data.vel_x, resp_data.vel_y, resp_data.vel_z,
                                     resp_data.saturated);
                        end
                    end
                end
            end
            outstanding = velocity_queue.size();
        end
    end

endmodule

### verif/filament_point_velocity_test.sv
module filament_point_velocity_test;
    import fpv_pkg::*;

    // index past the last register; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [31:0]   Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0]   Q_MIN = 32'sh80000000;
    localparam logic signed [31:0]   Q_ONE = 32'sd65536;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    fpv_in_t               req_data;
    logic                  resp_valid;
    logic                  resp_ready;
    fpv_out_t              resp_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    outstanding;
    int                    errors;
    int                    checked;

    // quiet turns off all idling on both channels for the closing part
    bit quiet;
    bit loaded [MAX_ELEMENTS];
    int requests_sent;

    filament_point_velocity u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp_data  (resp_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    filament_point_velocity_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .resp_valid  (resp_valid),
        .resp_ready  (resp_ready),
        .resp_data   (resp_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

    // Response side: hold ready low in short random bursts, never while quiet
    initial
    begin
        resp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                resp_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            resp_ready <= 1'b1;
        end
    end

    // Small coordinates (within +-4.0) give readable velocities; full range
    // exercises every bit and the saturation paths.
    function automatic logic signed [31:0] rand_q(bit full);
        if (full)
            return $urandom;
        return 32'($urandom_range(0, 524288)) - 32'sd262144;
    endfunction

    // Send one request; accepted at the edge where ready is seen high.
    task automatic send_request(fpv_in_t rq);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        do
            @(posedge clk);
        while (!req_ready);
        requests_sent++;
        if (rq.kind == KIND_LOAD)
            loaded[rq.element_index] = 1'b1;
    endtask

    task automatic load_element(int slot, logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz, logic signed [31:0] tx,
                                logic signed [31:0] ty, logic signed [31:0] tz);
        send_request('{KIND_LOAD, 10'(slot), px, py, pz, tx, ty, tz});
    endtask

    // Query with random junk in the ignored fields
    task automatic query_point(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
        send_request('{KIND_QUERY, 10'($urandom), px, py, pz, $urandom, $urandom, $urandom});
    endtask

    // Drop valid, drain every pending velocity, then let queued loads retire
    task automatic drain;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);
    endtask

    // Program all registers, one write per edge, plus a write to the unused index
    task automatic program_regs(int cnt, logic signed [31:0] gamma, logic [30:0] cutoff);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ELEMENT_COUNT;
        cfg_data  <= 32'(cnt);
        @(posedge clk);
        cfg_index <= REG_CIRCULATION;
        cfg_data  <= gamma;
        @(posedge clk);
        cfg_index <= REG_MIN_DISTANCE;
        cfg_data  <= {1'b0, cutoff};
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Length of the run of loaded slots from zero; queries never go past it
    function automatic int loaded_prefix();
        int i;
        for (i = 0; i < MAX_ELEMENTS; i++)
            if (!loaded[i])
                return i;
        return MAX_ELEMENTS;
    endfunction

    task automatic random_phase(int nreq);
        int          i, top, slot;
        logic [30:0] cutoff;
        top = loaded_prefix();
        if (top > 8)
            top = 8;
        case ($urandom_range(0, 3))
            0:       cutoff = 31'($urandom_range(0, 1024));
            1:       cutoff = 31'($urandom_range(0, 131072));
            2:       cutoff = 31'($urandom);
            default: cutoff = 31'd1;
        endcase
        program_regs($urandom_range(0, top),
                     ($urandom_range(0, 3) == 0) ? $urandom : rand_q(1'b0), cutoff);
        for (i = 0; i < nreq; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // mostly reload the low slots so later queries see fresh data
                slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, MAX_ELEMENTS - 1);
                load_element(slot, rand_q($urandom_range(0, 4) == 0),
                             rand_q($urandom_range(0, 4) == 0),
                             rand_q($urandom_range(0, 4) == 0),
                             rand_q($urandom_range(0, 3) == 0),
                             rand_q($urandom_range(0, 3) == 0),
                             rand_q($urandom_range(0, 3) == 0));
            end
            else
                query_point(rand_q($urandom_range(0, 5) == 0),
                            rand_q($urandom_range(0, 5) == 0),
                            rand_q($urandom_range(0, 5) == 0));
        end
        drain();
    endtask

    initial
    begin
        int i;
        quiet         = 1'b0;
        requests_sent = 0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_data      = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ELEMENT_COUNT;
        cfg_data      = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty sum with reset configuration
        query_point(Q_ONE, Q_ONE, Q_ONE);
        load_element(0, 0, 0, 0, Q_ONE, 0, 0);
        load_element(1, Q_MAX, Q_MIN, 0, Q_MAX, Q_MIN, Q_MAX);
        load_element(2, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN);
        load_element(3, 0, Q_ONE, 0, 0, 0, Q_ONE);
        for (i = 4; i < 8; i++)
            load_element(i, rand_q(1'b0), rand_q(1'b0), rand_q(1'b0),
                         rand_q(1'b0), rand_q(1'b0), rand_q(1'b0));
        // slot 1023 exercises the top index bits
        load_element(MAX_ELEMENTS - 1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        drain();

        // Zero cutoff, most negative circulation; point on element 0 is skipped
        program_regs(8, Q_MIN, 31'd0);
        query_point(0, 0, 0);
        query_point(Q_MAX, Q_MAX, Q_MAX);
        query_point(Q_MIN, Q_MIN, Q_MIN);
        query_point(0, 0, 32'sd1);
        drain();

        // Largest circulation; unit distance case
        program_regs(4, Q_MAX, 31'd1);
        query_point(0, 0, Q_ONE);
        query_point(Q_MIN, Q_MAX, 0);
        drain();

        // Largest cutoff: every nearby element skipped
        program_regs(8, Q_ONE, 31'h7fffffff);
        query_point(Q_ONE, 0, 0);
        query_point(Q_MIN, Q_MIN, Q_MIN);
        drain();

        // Random phases, new configuration each time
        for (i = 0; i < 8; i++)
            random_phase(60);

        // Closing part: no idling on either channel
        quiet = 1'b1;
        random_phase(40);

        repeat (100) @(posedge clk);
        $display("Covered %0d requests: element loads and point queries under %0s",
                 requests_sent, "directed and random register settings");
        $display("Compared %0d velocity results, %0d mismatches", checked, errors);
        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
